>>> hw/rtl/lcsr_pkg.sv
// shared types and constants of the column span rasterizer
package lcsr_pkg;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  localparam int SCREEN_BITS = 15;
  localparam int COLOUR_BITS = 32;
  localparam int CFG_INDEX_BITS = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 4'd1;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 15'd240;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 15'd120;

endpackage

>>> hw/rtl/lcsr_fifo.sv
// two-entry queue with the head always in the first slot
module lcsr_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  logic [1:0]    count;
  logic [DW-1:0] slot0;
  logic [DW-1:0] slot1;
  logic          push_ok;
  logic          pop_ok;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ok) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
        if (push_ok) begin
          slot1 <= wdata;
        end
      end else if (push_ok) begin
        slot0 <= wdata;
      end
    end else if (push_ok) begin
      if (count == 2'd0) begin
        slot0 <= wdata;
      end else begin
        slot1 <= wdata;
      end
    end
  end

endmodule

>>> hw/rtl/lcsr_front.sv
// front end: takes items, runs the slope division and start setup, queues commands
module lcsr_front #(
  parameter int C = 16,
  parameter int F = 16,
  localparam int AW = C + F + 4,
  localparam int CMD_BITS = 2 + 4 * C + 2 * AW + lcsr_pkg::COLOUR_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   kind,
  input  logic signed [C-1:0]    x_first,
  input  logic signed [C-1:0]    y_first,
  input  logic signed [C-1:0]    x_second,
  input  logic signed [C-1:0]    y_second,
  input  logic [31:0]            pixel_colour,
  output logic                   q_push,
  output logic [CMD_BITS-1:0]    q_data,
  input  logic                   q_full
);

  localparam int NB = C + 1 + F;
  localparam int SW = NB + 1;
  localparam int PW = SW + C + 3;
  localparam int CNTW = $clog2(NB);

  typedef struct packed {
    logic                  kind;
    logic                  vertical;
    logic signed [C-1:0]   col;
    logic signed [C-1:0]   endc;
    logic signed [C-1:0]   rl;
    logic signed [C-1:0]   rh;
    logic signed [AW-1:0]  vlo;
    logic signed [AW-1:0]  step2;
    logic [31:0]           colour;
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_SLOPE = 5'b00100,
    S_MUL   = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  state_t               state;
  logic signed [C-1:0]  xl, xu, yl, yu;
  logic [C:0]           dx;
  logic                 neg;
  logic [NB-1:0]        nsr;
  logic [C:0]           rem;
  logic [NB-1:0]        quo;
  logic [CNTW-1:0]      cnt;
  logic signed [SW-1:0] slope;
  cmd_t                 cmd_q;
  cmd_t                 step_cmd;

  logic                 accept;
  logic                 swap;
  logic signed [C-1:0]  xl_c, xu_c, yl_c, yu_c;
  logic signed [C:0]    dxs, dys;
  logic [C:0]           mag;
  logic [C+1:0]         rem_s;
  logic                 ge;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] two_c;
  logic signed [PW-1:0] vdiff;

  assign full   = (state != S_IDLE) || q_full;
  assign accept = push && !full;

  always_comb begin
    swap = x_first > x_second;
    xl_c = swap ? x_second : x_first;
    yl_c = swap ? y_second : y_first;
    xu_c = swap ? x_first : x_second;
    yu_c = swap ? y_first : y_second;
    dxs  = {xu_c[C-1], xu_c} - {xl_c[C-1], xl_c};
    dys  = {yu_c[C-1], yu_c} - {yl_c[C-1], yl_c};
    mag  = dys[C] ? -dys : dys;
  end

  assign rem_s = {rem, nsr[NB-1]};
  assign ge    = rem_s >= {1'b0, dx};
  assign prod  = slope * $signed({1'b0, dx, 1'b1});
  assign two_c = PW'(yu) <<< (F + 1);
  assign vdiff = two_c - prod;

  always_comb begin
    step_cmd      = '0;
    step_cmd.kind = lcsr_pkg::KIND_STEP;
  end

  assign q_push = (state == S_PUSH) || (accept && (kind == lcsr_pkg::KIND_STEP));
  assign q_data = (state == S_PUSH) ? cmd_q : step_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (kind == lcsr_pkg::KIND_START)) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == CNTW'(NB - 1)) begin
            state <= S_SLOPE;
          end
        end
        S_SLOPE: state <= S_MUL;
        S_MUL:   state <= S_PUSH;
        S_PUSH: begin
          if (!q_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && (kind == lcsr_pkg::KIND_START)) begin
          xl  <= xl_c;
          xu  <= xu_c;
          yl  <= yl_c;
          yu  <= yu_c;
          dx  <= dxs;
          neg <= dys[C];
          nsr <= {mag, {F{1'b0}}};
          rem <= '0;
          quo <= '0;
          cnt <= '0;
          cmd_q.colour <= pixel_colour;
        end
      end
      S_DIV: begin
        rem <= ge ? (rem_s[C:0] - dx) : rem_s[C:0];
        quo <= {quo[NB-2:0], ge};
        nsr <= {nsr[NB-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      S_SLOPE: begin
        if (dx == '0) begin
          slope <= '0;
        end else if (neg) begin
          slope <= -$signed({1'b0, quo}) - SW'(rem != '0);
        end else begin
          slope <= $signed({1'b0, quo});
        end
      end
      S_MUL: begin
        cmd_q.kind     <= lcsr_pkg::KIND_START;
        cmd_q.vertical <= (dx == '0);
        cmd_q.col      <= xl;
        cmd_q.endc     <= xu;
        cmd_q.rl       <= (yl < yu) ? yl : yu;
        cmd_q.rh       <= (yl < yu) ? yu : yl;
        cmd_q.vlo      <= vdiff[AW-1:0];
        cmd_q.step2    <= AW'($signed({slope, 1'b0}));
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/lcsr_back.sv
// back end: keeps the active line, steps the edge accumulator, clips spans
module lcsr_back #(
  parameter int C = 16,
  parameter int F = 16,
  localparam int AW = C + F + 4,
  localparam int CMD_BITS = 2 + 4 * C + 2 * AW + lcsr_pkg::COLOUR_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [lcsr_pkg::SCREEN_BITS-1:0]   screen_width,
  input  logic [lcsr_pkg::SCREEN_BITS-1:0]   screen_height,
  input  logic [CMD_BITS-1:0]                q_data,
  input  logic                               q_empty,
  output logic                               q_pop,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [C-1:0]                column_x,
  output logic [lcsr_pkg::SCREEN_BITS-1:0]   span_low_y,
  output logic [lcsr_pkg::SCREEN_BITS-1:0]   span_high_y,
  output logic [31:0]                        span_colour,
  output logic                               visible,
  output logic                               last
);

  localparam int SB = lcsr_pkg::SCREEN_BITS;
  localparam int YW = (C + 4 > SB + 2) ? C + 4 : SB + 2;
  localparam int ORW = C + 2 * SB + 34;

  typedef struct packed {
    logic                  kind;
    logic                  vertical;
    logic signed [C-1:0]   col;
    logic signed [C-1:0]   endc;
    logic signed [C-1:0]   rl;
    logic signed [C-1:0]   rh;
    logic signed [AW-1:0]  vlo;
    logic signed [AW-1:0]  step2;
    logic [31:0]           colour;
  } cmd_t;

  cmd_t                 cmd;
  logic                 active;
  logic                 vertical;
  logic signed [C-1:0]  x, endc, rl, rh;
  logic signed [AW-1:0] vlo, step2;
  logic [31:0]          colour;

  logic                 oq_full;
  logic                 emit;
  logic signed [AW-1:0] vhi;
  logic signed [YW-1:0] lo_f, hi_f, rlw, rhw, l1, h1, l2, h2, lo, hi;
  logic signed [YW-1:0] xw, sww, shw, lo_o, hi_o;
  logic                 vis, fin;
  logic [ORW-1:0]       o_wdata, o_rdata;

  assign cmd   = cmd_t'(q_data);
  assign q_pop = !q_empty && ((cmd.kind == lcsr_pkg::KIND_START) || !active || !oq_full);
  assign emit  = q_pop && (cmd.kind == lcsr_pkg::KIND_STEP) && active;
  assign vhi   = vlo + step2;

  always_comb begin
    lo_f = YW'($signed(vlo[AW-1:F+1]));
    hi_f = YW'($signed(vhi[AW-1:F+1]));
    rlw  = YW'(rl);
    rhw  = YW'(rh);
    l1   = (lo_f < rlw) ? rlw : lo_f;
    h1   = (hi_f > rhw) ? rhw : hi_f;
    l2   = (l1 > h1) ? h1 : l1;
    h2   = (l1 > h1) ? l1 : h1;
    lo   = vertical ? rlw : ((l2 < rlw) ? rlw : l2);
    hi   = vertical ? rhw : ((h2 > rhw) ? rhw : h2);
    xw   = YW'(x);
    sww  = $signed({{(YW - SB){1'b0}}, screen_width});
    shw  = $signed({{(YW - SB){1'b0}}, screen_height});
    vis  = (xw >= 0) && (xw < sww) && (hi >= 0) && (lo < shw);
    lo_o = '0;
    hi_o = '0;
    if (vis) begin
      lo_o = (lo < 0) ? '0 : lo;
      hi_o = (hi > shw - YW'(1)) ? shw - YW'(1) : hi;
    end
    fin  = vertical || (x >= endc);
  end

  assign o_wdata = {x, lo_o[SB-1:0], hi_o[SB-1:0], colour, vis, fin};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_pop) begin
      if (cmd.kind == lcsr_pkg::KIND_START) begin
        active <= 1'b1;
      end else if (emit && fin) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (cmd.kind == lcsr_pkg::KIND_START)) begin
      vertical <= cmd.vertical;
      x        <= cmd.col;
      endc     <= cmd.endc;
      rl       <= cmd.rl;
      rh       <= cmd.rh;
      vlo      <= cmd.vlo;
      step2    <= cmd.step2;
      colour   <= cmd.colour;
    end else if (emit && !fin) begin
      x   <= x + 1'b1;
      vlo <= vhi;
    end
  end

  lcsr_fifo #(.DW(ORW)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (emit),
    .wdata (o_wdata),
    .full  (oq_full),
    .pop   (pop),
    .rdata (o_rdata),
    .empty (empty)
  );

  assign column_x    = $signed(o_rdata[ORW-1 -: C]);
  assign span_low_y  = o_rdata[2*SB+33 -: SB];
  assign span_high_y = o_rdata[SB+33 -: SB];
  assign span_colour = o_rdata[33:2];
  assign visible     = o_rdata[1];
  assign last        = o_rdata[0];

endmodule

>>> hw/rtl/line_column_span_rasterizer.sv
// top level of the column span line rasterizer
// A start beat (kind 0) loads two endpoints and a colour and yields no span; each step beat
// (kind 1) yields one span for the next column, left to right, with last set on the rightmost
// column, and a step with no line in progress yields nothing. Step beats are taken one per
// cycle while no start beat is in setup and the command queue has room. A start beat holds
// full high while the bit-serial slope divider runs (one quotient bit per cycle) and then
// through the slope sign fixup, the intercept multiply and the command queue hand-off, which
// waits while the command queue is full because unpopped spans stall the back end.
// Spans wait in a two-entry output queue, so input keeps flowing while a span is not yet
// popped. Screen size registers are written through the cfg port (always ready); write them
// only while no line work is in flight. No clearing pass is needed after reset.
module line_column_span_rasterizer #(
  parameter int COORD_BITS = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input side
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   kind,
  input  logic signed [COORD_BITS-1:0]           x_first,
  input  logic signed [COORD_BITS-1:0]           y_first,
  input  logic signed [COORD_BITS-1:0]           x_second,
  input  logic signed [COORD_BITS-1:0]           y_second,
  input  logic [31:0]                            pixel_colour,
  // result side
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [COORD_BITS-1:0]           column_x,
  output logic [lcsr_pkg::SCREEN_BITS-1:0]       span_low_y,
  output logic [lcsr_pkg::SCREEN_BITS-1:0]       span_high_y,
  output logic [31:0]                            span_colour,
  output logic                                   visible,
  output logic                                   last,
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lcsr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [lcsr_pkg::SCREEN_BITS-1:0]       cfg_data
);

  // accumulator width and command word width, kept in step with front and back
  localparam int AW = COORD_BITS + FRACTION_BITS + 4;
  localparam int CMD_BITS = 2 + 4 * COORD_BITS + 2 * AW + lcsr_pkg::COLOUR_BITS;

  logic [lcsr_pkg::SCREEN_BITS-1:0] screen_width;
  logic [lcsr_pkg::SCREEN_BITS-1:0] screen_height;

  logic                q_push, q_full, q_pop, q_empty;
  logic [CMD_BITS-1:0] q_wdata, q_rdata;

  // register file, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lcsr_pkg::SCREEN_WIDTH_RESET;
      screen_height <= lcsr_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == lcsr_pkg::REG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end else if (cfg_index == lcsr_pkg::REG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data;
      end
    end
  end

  // front: orders endpoints, divides for the slope, seeds the half-column accumulator
  lcsr_front #(.C(COORD_BITS), .F(FRACTION_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .x_first      (x_first),
    .y_first      (y_first),
    .x_second     (x_second),
    .y_second     (y_second),
    .pixel_colour (pixel_colour),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  // short command queue decouples the divider from the stepping
  lcsr_fifo #(.DW(CMD_BITS)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: one span per step of an active line, the accumulator advances by twice the slope per column
  lcsr_back #(.C(COORD_BITS), .F(FRACTION_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .q_data        (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .column_x      (column_x),
    .span_low_y    (span_low_y),
    .span_high_y   (span_high_y),
    .span_colour   (span_colour),
    .visible       (visible),
    .last          (last)
  );

endmodule

>>> hw/rtl/lcsr_checker.sv
// port checker for the rasterizer and its bind
module lcsr_checker #(
  parameter int C = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                empty,
  input logic                                pop,
  input logic signed [C-1:0]                 column_x,
  input logic [lcsr_pkg::SCREEN_BITS-1:0]    span_low_y,
  input logic [lcsr_pkg::SCREEN_BITS-1:0]    span_high_y,
  input logic [31:0]                         span_colour,
  input logic                                visible
);

  a_held_span: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(column_x) && $stable(span_colour))
    else $error("waiting span changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result after reset");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !visible |-> span_low_y == '0 && span_high_y == '0)
    else $error("hidden span has rows");

  a_span_order: assert property (@(posedge clk) disable iff (rst)
    !empty && visible |-> span_low_y <= span_high_y)
    else $error("span rows reversed");

endmodule

bind line_column_span_rasterizer lcsr_checker #(.C(COORD_BITS)) u_checker (.*);

>>> sim/tb_line_column_span_rasterizer.sv
// testbench of the column span line rasterizer
`timescale 1ns / 100ps

module tb_line_column_span_rasterizer;

  // cycle limit for the whole run, far above the slowest legal run
  localparam int CYCLE_LIMIT = 3000000;
  // a start beat keeps the block busy without giving a span
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    lcsr_pkg::kind_t    kind;
    logic signed [15:0] xa;
    logic signed [15:0] ya;
    logic signed [15:0] xb;
    logic signed [15:0] yb;
    logic [31:0]        colour;
  } line_cmd_t;

  typedef struct packed {
    logic signed [15:0]                col;
    logic [lcsr_pkg::SCREEN_BITS-1:0]  low_y;
    logic [lcsr_pkg::SCREEN_BITS-1:0]  high_y;
    logic [31:0]                       colour;
    logic                              vis;
    logic                              fin;
  } span_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic kind = lcsr_pkg::KIND_START;
  logic signed [15:0] x_first = '0;
  logic signed [15:0] y_first = '0;
  logic signed [15:0] x_second = '0;
  logic signed [15:0] y_second = '0;
  logic [31:0] pixel_colour = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] column_x;
  logic [lcsr_pkg::SCREEN_BITS-1:0] span_low_y;
  logic [lcsr_pkg::SCREEN_BITS-1:0] span_high_y;
  logic [31:0] span_colour;
  logic visible;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lcsr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [lcsr_pkg::SCREEN_BITS-1:0] cfg_data = '0;

  line_column_span_rasterizer DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .kind(kind),
    .x_first(x_first), .y_first(y_first), .x_second(x_second), .y_second(y_second),
    .pixel_colour(pixel_colour),
    .empty(empty), .pop(pop),
    .column_x(column_x), .span_low_y(span_low_y), .span_high_y(span_high_y),
    .span_colour(span_colour), .visible(visible), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // beats waiting to be driven, and spans still owed by the block
  line_cmd_t cmd_backlog[$];
  span_t     spans_owed[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // predictor copy of the block state
  int      scr_w = 240;
  int      scr_h = 120;
  bit      ln_busy = 1'b0;
  bit      ln_upright = 1'b0;
  longint  col_next = 0;
  longint  col_end = 0;
  longint  y_floor = 0;
  longint  y_ceil = 0;
  longint  grad = 0;
  longint  y_at_end = 0;
  logic [31:0] ink = '0;

  // advance the line state by one beat; returns 1 when a span comes out
  function automatic bit rasterize(input line_cmd_t c, output span_t s);
    longint xl, yl, xu, yu, dx, dy, d, lo, hi, t, x;
    bit vis;
    s = '0;
    if (c.kind == lcsr_pkg::KIND_START) begin
      if (c.xa > c.xb) begin
        xl = c.xb; yl = c.yb; xu = c.xa; yu = c.ya;
      end else begin
        xl = c.xa; yl = c.ya; xu = c.xb; yu = c.yb;
      end
      dx = xu - xl;
      dy = yu - yl;
      // slope rounds toward minus infinity
      if (dx == 0) grad = 0;
      else if (dy >= 0) grad = (dy <<< 16) / dx;
      else grad = -((((-dy) <<< 16) + dx - 1) / dx);
      ln_upright = (dx == 0);
      y_at_end = yu <<< 16;
      col_next = xl;
      col_end = xu;
      y_floor = (yl < yu) ? yl : yu;
      y_ceil = (yl < yu) ? yu : yl;
      ink = c.colour;
      ln_busy = 1'b1;
      return 1'b0;
    end
    if (!ln_busy) return 1'b0;
    x = col_next;
    if (ln_upright) begin
      lo = y_floor;
      hi = y_ceil;
    end else begin
      // y at both column edges, floored by the arithmetic shift
      d = x - col_end;
      lo = (grad * (2 * d - 1) + 2 * y_at_end) >>> 17;
      hi = (grad * (2 * d + 1) + 2 * y_at_end) >>> 17;
      if (lo < y_floor) lo = y_floor;
      if (hi > y_ceil) hi = y_ceil;
      if (lo > hi) begin
        t = lo; lo = hi; hi = t;
      end
      if (lo < y_floor) lo = y_floor;
      if (hi > y_ceil) hi = y_ceil;
    end
    vis = (x >= 0) && (x < scr_w) && (hi >= 0) && (lo < scr_h);
    if (vis) begin
      if (lo < 0) lo = 0;
      if (hi > scr_h - 1) hi = scr_h - 1;
    end else begin
      lo = 0;
      hi = 0;
    end
    s.col = x[15:0];
    s.low_y = lo[lcsr_pkg::SCREEN_BITS-1:0];
    s.high_y = hi[lcsr_pkg::SCREEN_BITS-1:0];
    s.colour = ink;
    s.vis = vis;
    s.fin = ln_upright || (x >= col_end);
    if (s.fin) ln_busy = 1'b0;
    else col_next = x + 1;
    return 1'b1;
  endfunction

  // driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    span_t s;
    line_cmd_t c;
    bit hold_beat;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      push <= 1'b0;
    end else begin
      hold_beat = push && full;
      if (push && !full) begin
        c.kind = lcsr_pkg::kind_t'(kind);
        c.xa = x_first; c.ya = y_first; c.xb = x_second; c.yb = y_second;
        c.colour = pixel_colour;
        if (rasterize(c, s)) spans_owed.push_back(s);
      end
      if (!hold_beat) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = cmd_backlog.pop_front();
          push <= 1'b1;
          kind <= c.kind;
          x_first <= c.xa; y_first <= c.ya; x_second <= c.xb; y_second <= c.yb;
          pixel_colour <= c.colour;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: check each popped span against the oldest prediction
  always @(posedge clk) begin
    span_t e;
    if (!rst && pop && !empty) begin
      if (spans_owed.size() == 0) begin
        $display("%0t: span with none expected: x=%0d lo=%0d hi=%0d", $time,
                 column_x, span_low_y, span_high_y);
        fail_count <= fail_count + 1;
      end else begin
        e = spans_owed.pop_front();
        if (column_x !== e.col || span_low_y !== e.low_y || span_high_y !== e.high_y ||
            span_colour !== e.colour || visible !== e.vis || last !== e.fin) begin
          $display("%0t: span mismatch expected x=%0d lo=%0d hi=%0d col=%h vis=%b last=%b",
                   $time, e.col, e.low_y, e.high_y, e.colour, e.vis, e.fin);
          $display("%0t:                 actual x=%0d lo=%0d hi=%0d col=%h vis=%b last=%b",
                   $time, column_x, span_low_y, span_high_y, span_colour, visible, last);
          fail_count <= fail_count + 1;
        end
      end
    end
    pop <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_line_column_span_rasterizer failed");
      $finish;
    end
  end

  task automatic add_cmd(input lcsr_pkg::kind_t k, input int xa, input int ya, input int xb,
                         input int yb, input logic [31:0] colour);
    line_cmd_t c;
    c.kind = k;
    c.xa = xa[15:0]; c.ya = ya[15:0]; c.xb = xb[15:0]; c.yb = yb[15:0];
    c.colour = colour;
    cmd_backlog.push_back(c);
  endtask

  // a start beat followed by steps; step beats carry random junk endpoints
  task automatic add_line(input int xa, input int ya, input int xb, input int yb,
                          input logic [31:0] colour, input int steps);
    add_cmd(lcsr_pkg::KIND_START, xa, ya, xb, yb, colour);
    repeat (steps)
      add_cmd(lcsr_pkg::KIND_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // only written while nothing is in flight
  task automatic write_reg(input logic [lcsr_pkg::CFG_INDEX_BITS-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[lcsr_pkg::SCREEN_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == lcsr_pkg::REG_SCREEN_WIDTH) scr_w = value & 32'h7FFF;
    else if (idx == lcsr_pkg::REG_SCREEN_HEIGHT) scr_h = value & 32'h7FFF;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    wait (cmd_backlog.size() == 0 && !push);
    wait (spans_owed.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random lines, mostly near the screen and stepped to the end
  task automatic add_random_lines(input int count);
    int xa, ya, dx, dy, steps, sent, w, h;
    sent = 0;
    w = (scr_w > 0) ? scr_w : 16;
    h = (scr_h > 0) ? scr_h : 16;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        // wild endpoints anywhere, abandoned after a few columns
        steps = $urandom_range(4);
        add_line($urandom, $urandom, $urandom, $urandom, $urandom, steps);
      end else begin
        xa = int'($urandom_range(w + 16)) - 8;
        ya = int'($urandom_range(h + 16)) - 8;
        dx = int'($urandom_range(60)) - 30;
        dy = int'($urandom_range(400)) - 200;
        if ($urandom_range(5) == 0) dx = 0;
        steps = (dx < 0 ? -dx : dx) + 1;
        case ($urandom_range(9))
          0: begin
            steps = $urandom_range(steps);
          end
          1: begin
            steps = steps + $urandom_range(2);
          end
          default: begin
          end
        endcase
        add_line(xa, ya, xa + dx, ya + dy, $urandom, steps);
      end
      sent += steps + 1;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset screen size 240 x 120
    add_cmd(lcsr_pkg::KIND_STEP, 0, 0, 0, 0, 0);         // step with no line
    add_line(5, 10, 5, 3, 32'hFFFF_FFFF, 2);             // vertical, extra step ignored
    add_line(-32768, -32768, 32767, 32767, 32'h0, 2);    // extreme corners, abandoned
    add_line(32767, 32767, -32768, -32768, 32'hA5A5_5A5A, 1);
    add_line(-5, 10, -3, 20, 32'h1234_5678, 3);          // left of screen
    add_line(2, -10, 4, 200, 32'h0F0F_0F0F, 3);          // clipped top and bottom
    add_line(10, 5, 7, 50, 32'hDEAD_BEEF, 4);            // reversed, steep
    add_line(238, 60, 242, 58, 32'hCAFE_F00D, 5);        // right edge, shallow down
    drain();

    // random phases with different screen sizes and idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(lcsr_pkg::REG_SCREEN_WIDTH, 240);
          write_reg(lcsr_pkg::REG_SCREEN_HEIGHT, 120);
        end
        1: begin
          write_reg(lcsr_pkg::REG_SCREEN_WIDTH, 1);
          write_reg(lcsr_pkg::REG_SCREEN_HEIGHT, 1);
        end
        2: begin
          write_reg(lcsr_pkg::REG_SCREEN_WIDTH, 32767);
          write_reg(lcsr_pkg::REG_SCREEN_HEIGHT, 32767);
        end
        3: begin
          write_reg(lcsr_pkg::REG_SCREEN_WIDTH, 0);
          write_reg(lcsr_pkg::REG_SCREEN_HEIGHT, 0);
        end
        4: begin
          // unused index must change nothing
          write_reg(4'd9, 5);
          write_reg(lcsr_pkg::REG_SCREEN_WIDTH, 64);
          write_reg(lcsr_pkg::REG_SCREEN_HEIGHT, 48);
        end
        default: begin
          write_reg(lcsr_pkg::REG_SCREEN_WIDTH, 20);
          write_reg(lcsr_pkg::REG_SCREEN_HEIGHT, 32767);
        end
      endcase
      send_idle_pct = (ph == 1 || ph == 4) ? 87 : (ph == 3 ? 32 : 0);
      recv_stall_pct = (ph == 2 || ph == 4) ? 87 : (ph == 3 ? 32 : 0);
      add_random_lines(100);
      if (ph == 0) begin
        // sender holds off until every span is back
        wait (cmd_backlog.size() == 0 && !push);
        wait (spans_owed.size() == 0);
      end
      add_random_lines(100);
      drain();
    end

    if (fail_count == 0)
      $display("tb_line_column_span_rasterizer passed");
    else
      $display("tb_line_column_span_rasterizer failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/lcsr_pkg.sv
hw/rtl/lcsr_fifo.sv
hw/rtl/lcsr_front.sv
hw/rtl/lcsr_back.sv
hw/rtl/line_column_span_rasterizer.sv
hw/rtl/lcsr_checker.sv
sim/tb_line_column_span_rasterizer.sv
